// ===== rtl/core/ved_pkg.sv =====
// Package for the visual escape decoder: phase codes, result status codes and
// the named-entity ROM with its lookup helpers. Depends on nothing.
package ved_pkg;

    localparam int ENTITY_ROWS_DEF = 33;
    localparam int NAME_CHARS_DEF  = 7;

    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [4:0] PH_PLAIN    = 5'd0;
    localparam logic [4:0] PH_BSL      = 5'd1;
    localparam logic [4:0] PH_OCT2     = 5'd2;
    localparam logic [4:0] PH_OCT3     = 5'd3;
    localparam logic [4:0] PH_META     = 5'd4;
    localparam logic [4:0] PH_METADASH = 5'd5;
    localparam logic [4:0] PH_CTRL     = 5'd6;
    localparam logic [4:0] PH_PCT      = 5'd7;
    localparam logic [4:0] PH_XFIRST   = 5'd8;
    localparam logic [4:0] PH_XSECOND  = 5'd9;
    localparam logic [4:0] PH_EQ       = 5'd10;
    localparam logic [4:0] PH_EQHALF   = 5'd11;
    localparam logic [4:0] PH_EQSOFT   = 5'd12;
    localparam logic [4:0] PH_AMP      = 5'd13;
    localparam logic [4:0] PH_AMPHASH  = 5'd14;
    localparam logic [4:0] PH_AMPHEX0  = 5'd15;
    localparam logic [4:0] PH_AMPHEX   = 5'd16;
    localparam logic [4:0] PH_AMPDEC   = 5'd17;
    localparam logic [4:0] PH_AMPNAME  = 5'd18;

    typedef logic [55:0] ent_name_t;

    // Names are left-justified, first character in the top byte, zero padded.
    function automatic ent_name_t ent_name(input logic [5:0] row);
        ent_name_t n;
        case (row)
            6'd0:    n = {"Hat", 32'h0};
            6'd1:    n = "NewLine";
            6'd2:    n = {"Tab", 32'h0};
            6'd3:    n = {"amp", 32'h0};
            6'd4:    n = {"apos", 24'h0};
            6'd5:    n = {"ast", 32'h0};
            6'd6:    n = {"bne", 32'h0};
            6'd7:    n = {"bsol", 24'h0};
            6'd8:    n = {"colon", 16'h0};
            6'd9:    n = {"comma", 16'h0};
            6'd10:   n = {"commat", 8'h0};
            6'd11:   n = {"dollar", 8'h0};
            6'd12:   n = {"excl", 24'h0};
            6'd13:   n = {"fjlig", 16'h0};
            6'd14:   n = {"grave", 16'h0};
            6'd15:   n = {"gt", 40'h0};
            6'd16:   n = {"lcub", 24'h0};
            6'd17:   n = {"lowbar", 8'h0};
            6'd18:   n = {"lpar", 24'h0};
            6'd19:   n = {"lsqb", 24'h0};
            6'd20:   n = {"lt", 40'h0};
            6'd21:   n = {"num", 32'h0};
            6'd22:   n = {"percnt", 8'h0};
            6'd23:   n = {"period", 8'h0};
            6'd24:   n = {"plus", 24'h0};
            6'd25:   n = {"quest", 16'h0};
            6'd26:   n = {"quot", 24'h0};
            6'd27:   n = {"rcub", 24'h0};
            6'd28:   n = {"rpar", 24'h0};
            6'd29:   n = {"rsqb", 24'h0};
            6'd30:   n = {"semi", 24'h0};
            6'd31:   n = {"sol", 32'h0};
            6'd32:   n = {"vert", 24'h0};
            default: n = '0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] ent_val(input logic [5:0] row);
        logic [7:0] v;
        case (row)
            6'd0:    v = 8'h5e;
            6'd1:    v = 8'h0a;
            6'd2:    v = 8'h09;
            6'd3:    v = 8'h26;
            6'd4:    v = 8'h27;
            6'd5:    v = 8'h2a;
            6'd6:    v = 8'h3d;
            6'd7:    v = 8'h5c;
            6'd8:    v = 8'h3a;
            6'd9:    v = 8'h2c;
            6'd10:   v = 8'h40;
            6'd11:   v = 8'h24;
            6'd12:   v = 8'h21;
            6'd13:   v = 8'h66;
            6'd14:   v = 8'h60;
            6'd15:   v = 8'h3e;
            6'd16:   v = 8'h7b;
            6'd17:   v = 8'h5f;
            6'd18:   v = 8'h28;
            6'd19:   v = 8'h5b;
            6'd20:   v = 8'h3c;
            6'd21:   v = 8'h23;
            6'd22:   v = 8'h25;
            6'd23:   v = 8'h2e;
            6'd24:   v = 8'h2b;
            6'd25:   v = 8'h3f;
            6'd26:   v = 8'h22;
            6'd27:   v = 8'h7d;
            6'd28:   v = 8'h29;
            6'd29:   v = 8'h5d;
            6'd30:   v = 8'h3b;
            6'd31:   v = 8'h2f;
            6'd32:   v = 8'h7c;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] ent_char(input logic [5:0] row, input logic [2:0] idx);
        ent_name_t n;
        n = ent_name(row) << {idx, 3'b000};
        return n[55:48];
    endfunction

    // True when rows row and row+1 agree in their first len characters.
    function automatic logic ent_prefix_ok(input logic [5:0] row, input logic [2:0] len);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 7; i++)
        begin
            if (3'(i) < len && ent_char(row, 3'(i)) != ent_char(row + 6'd1, 3'(i)))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// ===== rtl/core/visual_escape_decoder.sv =====
// Top level of the visual escape decoder: APB register, input and output
// word channels, the decode sequencer and the entity ROM scan.
// Depends on ved_pkg.
//
// Usage: an input word carries mode and data_byte. Mode 0 feeds one raw byte
// through the escape decoder; mode 1 marks end of input and flushes a pending
// octal or hex value. Each input word yields one or two output words (status,
// out_byte, last); last is high on the final one. A run of octal or hex digits
// ended by another byte yields the built byte first, then the result for the
// terminating byte.
// Timing: in_ready is high only while the block is idle, so a new word is
// not taken until the last result has been accepted. A word is decoded in
// the cycle after acceptance and, unless it starts a named entity scan, its
// result is offered in the next cycle. A named entity character walks the
// entity ROM one row per cycle, examining at most ENTITY_ROWS rows.
// Reset clears the style register, the decode phase and the sequencer state.
// When out_ready is low the result is held unchanged and no input is taken.
module visual_escape_decoder #(
    parameter int ENTITY_ROWS = ved_pkg::ENTITY_ROWS_DEF,
    parameter int NAME_CHARS  = ved_pkg::NAME_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  out_byte,
    output logic        last
);
    import ved_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [2:0] RC_VALID = 3'd0;
    localparam logic [2:0] RC_NONE  = 3'd1;
    localparam logic [2:0] RC_BAD   = 3'd2;
    localparam logic [2:0] RC_PUSH  = 3'd3;
    localparam logic [2:0] RC_SCAN  = 3'd4;

    logic [1:0] state_reg, state_next;
    logic [3:0] style_reg;
    logic       mode_reg;
    logic [7:0] ch_reg;
    logic [4:0] phase_reg, phase_next;
    logic [7:0] acc_reg, acc_next;
    logic [5:0] row_reg, row_next;
    logic [2:0] len_reg, len_next;
    logic [5:0] pos_reg, pos_next;
    logic       push_reg, push_next;
    logic [1:0] status_reg, status_next;
    logic [7:0] obyte_reg, obyte_next;
    logic       last_reg, last_next;

    logic [2:0]  d_rc;
    logic [4:0]  d_phase;
    logic [7:0]  d_acc;
    logic [7:0]  d_byte;
    logic        d_amp;
    logic        hex_ok;
    logic [3:0]  hex_v;
    logic [11:0] dec_sum;
    logic [7:0]  key;
    logic [6:0]  pos_inc;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && !paddr[2];
    assign prdata    = paddr[2] ? 32'h0 : {28'h0, style_reg};
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign status    = status_reg;
    assign out_byte  = obyte_reg;
    assign last      = last_reg;

    always_comb
    begin
        hex_ok = 1'b1;
        hex_v  = 4'h0;
        if (ch_reg inside {[8'h30:8'h39]})
        begin
            hex_v = ch_reg[3:0];
        end
        else if (ch_reg inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            hex_v = 4'(ch_reg[2:0] + 3'd1) + 4'd8;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign dec_sum = 12'({acc_reg, 3'b000}) + 12'({acc_reg, 1'b0}) + 12'(ch_reg[3:0]);
    assign key     = (ch_reg == 8'h3b) ? 8'h00 : ch_reg;
    assign pos_inc = 7'(pos_reg) + 7'd1;

    // One decode step for the current phase and byte.
    always_comb
    begin
        d_rc    = RC_NONE;
        d_phase = PH_PLAIN;
        d_acc   = acc_reg;
        d_byte  = 8'h00;
        d_amp   = 1'b0;
        if (mode_reg)
        begin
            if (phase_reg == PH_OCT2 || phase_reg == PH_OCT3 || phase_reg == PH_XSECOND)
            begin
                d_rc   = RC_VALID;
                d_byte = acc_reg;
            end
            else if (phase_reg == PH_PLAIN)
            begin
                d_rc = RC_NONE;
            end
            else
            begin
                d_rc = RC_BAD;
            end
        end
        else
        begin
            case (phase_reg)
                PH_PLAIN:
                begin
                    if (ch_reg == 8'h5c && !style_reg[0])
                    begin
                        d_phase = PH_BSL;
                    end
                    else if (ch_reg == 8'h25 && style_reg[1])
                    begin
                        d_acc   = 8'h00;
                        d_phase = PH_PCT;
                    end
                    else if (ch_reg == 8'h3d && style_reg[2])
                    begin
                        d_phase = PH_EQ;
                    end
                    else if (ch_reg == 8'h26 && style_reg[3])
                    begin
                        d_phase = PH_AMP;
                    end
                    else
                    begin
                        d_rc   = RC_VALID;
                        d_byte = ch_reg;
                    end
                end
                PH_BSL:
                begin
                    d_rc = RC_VALID;
                    case (ch_reg) inside
                        [8'h30:8'h37]:
                        begin
                            d_rc    = RC_NONE;
                            d_acc   = {5'b0, ch_reg[2:0]};
                            d_phase = PH_OCT2;
                        end
                        8'h4d:
                        begin
                            d_rc    = RC_NONE;
                            d_acc   = 8'h80;
                            d_phase = PH_META;
                        end
                        8'h5e:
                        begin
                            d_rc    = RC_NONE;
                            d_acc   = 8'h00;
                            d_phase = PH_CTRL;
                        end
                        8'h78:
                        begin
                            d_rc    = RC_NONE;
                            d_acc   = 8'h00;
                            d_phase = PH_XFIRST;
                        end
                        8'h6e:        d_byte = 8'h0a;
                        8'h72:        d_byte = 8'h0d;
                        8'h62:        d_byte = 8'h08;
                        8'h61:        d_byte = 8'h07;
                        8'h76:        d_byte = 8'h0b;
                        8'h74:        d_byte = 8'h09;
                        8'h66:        d_byte = 8'h0c;
                        8'h73:        d_byte = 8'h20;
                        8'h65, 8'h45: d_byte = 8'h1b;
                        8'h24, 8'h0a: d_rc   = RC_NONE;
                        [8'h21:8'h7e]: d_byte = ch_reg;
                        default:      d_rc   = RC_BAD;
                    endcase
                end
                PH_OCT2, PH_OCT3:
                begin
                    if (ch_reg inside {[8'h30:8'h37]})
                    begin
                        d_acc = {acc_reg[4:0], ch_reg[2:0]};
                        if (phase_reg == PH_OCT3)
                        begin
                            d_rc   = RC_VALID;
                            d_byte = {acc_reg[4:0], ch_reg[2:0]};
                        end
                        else
                        begin
                            d_phase = PH_OCT3;
                        end
                    end
                    else
                    begin
                        d_rc   = RC_PUSH;
                        d_byte = acc_reg;
                    end
                end
                PH_META:
                begin
                    if (ch_reg == 8'h2d)
                    begin
                        d_phase = PH_METADASH;
                    end
                    else if (ch_reg == 8'h5e)
                    begin
                        d_phase = PH_CTRL;
                    end
                    else
                    begin
                        d_rc = RC_BAD;
                    end
                end
                PH_METADASH:
                begin
                    d_rc   = RC_VALID;
                    d_byte = acc_reg | ch_reg;
                end
                PH_CTRL:
                begin
                    d_rc   = RC_VALID;
                    d_byte = acc_reg | ((ch_reg == 8'h3f) ? 8'h7f : (ch_reg & 8'h1f));
                end
                PH_XFIRST, PH_PCT, PH_XSECOND:
                begin
                    if (!hex_ok)
                    begin
                        if (phase_reg == PH_XFIRST)
                        begin
                            d_rc = RC_BAD;
                        end
                        else
                        begin
                            d_rc   = RC_PUSH;
                            d_byte = acc_reg;
                        end
                    end
                    else
                    begin
                        d_acc = {acc_reg[3:0], hex_v};
                        if (phase_reg == PH_XSECOND)
                        begin
                            d_rc   = RC_VALID;
                            d_byte = {acc_reg[3:0], hex_v};
                        end
                        else
                        begin
                            d_phase = PH_XSECOND;
                        end
                    end
                end
                PH_EQ:
                begin
                    if (ch_reg == 8'h0d || ch_reg == 8'h0a)
                    begin
                        d_phase = PH_EQSOFT;
                    end
                    else if (ch_reg inside {[8'h30:8'h39], [8'h41:8'h46]})
                    begin
                        d_acc   = {hex_v, 4'h0};
                        d_phase = PH_EQHALF;
                    end
                    else
                    begin
                        d_rc = RC_BAD;
                    end
                end
                PH_EQHALF:
                begin
                    if (ch_reg inside {[8'h30:8'h39], [8'h41:8'h46]})
                    begin
                        d_rc   = RC_VALID;
                        d_byte = acc_reg | {4'h0, hex_v};
                    end
                    else
                    begin
                        d_rc = RC_BAD;
                    end
                end
                PH_EQSOFT:
                begin
                    if (ch_reg == 8'h0d || ch_reg == 8'h0a)
                    begin
                        d_phase = PH_EQSOFT;
                    end
                    else if (ch_reg == 8'h3d)
                    begin
                        d_phase = PH_EQ;
                    end
                    else
                    begin
                        d_rc   = RC_VALID;
                        d_byte = ch_reg;
                    end
                end
                PH_AMP:
                begin
                    d_acc = 8'h00;
                    if (ch_reg == 8'h23)
                    begin
                        d_phase = PH_AMPHASH;
                    end
                    else
                    begin
                        d_amp = 1'b1;
                        d_rc  = (ch_reg == 8'h00) ? RC_BAD : RC_SCAN;
                    end
                end
                PH_AMPHASH, PH_AMPDEC:
                begin
                    if (phase_reg == PH_AMPHASH && ch_reg == 8'h78)
                    begin
                        d_phase = PH_AMPHEX0;
                    end
                    else if (phase_reg == PH_AMPDEC && ch_reg == 8'h3b)
                    begin
                        d_rc   = RC_VALID;
                        d_byte = acc_reg;
                    end
                    else if (!(ch_reg inside {[8'h30:8'h39]}) || dec_sum > 12'd255)
                    begin
                        d_rc = RC_BAD;
                    end
                    else
                    begin
                        d_acc   = dec_sum[7:0];
                        d_phase = PH_AMPDEC;
                    end
                end
                PH_AMPHEX0:
                begin
                    if (hex_ok)
                    begin
                        d_acc   = {4'h0, hex_v};
                        d_phase = PH_AMPHEX;
                    end
                    else
                    begin
                        d_rc = RC_BAD;
                    end
                end
                PH_AMPHEX:
                begin
                    if (ch_reg == 8'h3b)
                    begin
                        d_rc   = RC_VALID;
                        d_byte = acc_reg;
                    end
                    else if (!hex_ok || acc_reg[7:4] != 4'h0)
                    begin
                        d_rc = RC_BAD;
                    end
                    else
                    begin
                        d_acc   = {acc_reg[3:0], hex_v};
                        d_phase = PH_AMPHEX;
                    end
                end
                PH_AMPNAME:
                begin
                    if (len_reg >= 3'(NAME_CHARS) || row_reg >= 6'(ENTITY_ROWS)
                        || ch_reg == 8'h00)
                    begin
                        d_rc = RC_BAD;
                    end
                    else
                    begin
                        d_rc = RC_SCAN;
                    end
                end
                default: d_rc = RC_BAD;
            endcase
        end
    end

    // Sequencer: decode, ROM scan one row per cycle, result hold.
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        row_next    = row_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        push_next   = push_reg;
        status_next = status_reg;
        obyte_next  = obyte_reg;
        last_next   = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                phase_next = d_phase;
                acc_next   = d_acc;
                push_next  = 1'b0;
                last_next  = 1'b1;
                obyte_next = 8'h00;
                if (d_amp)
                begin
                    row_next = 6'd0;
                    len_next = 3'd0;
                end
                case (d_rc)
                    RC_VALID:
                    begin
                        status_next = ST_BYTE;
                        obyte_next  = d_byte;
                        state_next  = S_OUT;
                    end
                    RC_PUSH:
                    begin
                        status_next = ST_BYTE;
                        obyte_next  = d_byte;
                        push_next   = 1'b1;
                        last_next   = 1'b0;
                        state_next  = S_OUT;
                    end
                    RC_NONE:
                    begin
                        status_next = ST_NONE;
                        state_next  = S_OUT;
                    end
                    RC_SCAN:
                    begin
                        pos_next   = d_amp ? 6'd0 : row_reg;
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        status_next = ST_ERROR;
                        state_next  = S_OUT;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (ent_char(pos_reg, len_reg) == key)
                begin
                    state_next = S_OUT;
                    if (key == 8'h00)
                    begin
                        status_next = ST_BYTE;
                        obyte_next  = ent_val(pos_reg);
                        phase_next  = PH_PLAIN;
                    end
                    else
                    begin
                        status_next = ST_NONE;
                        row_next    = pos_reg;
                        len_next    = len_reg + 3'd1;
                        phase_next  = PH_AMPNAME;
                    end
                end
                else if (pos_inc >= 7'(ENTITY_ROWS) || !ent_prefix_ok(pos_reg, len_reg))
                begin
                    status_next = ST_ERROR;
                    phase_next  = PH_PLAIN;
                    state_next  = S_OUT;
                end
                else
                begin
                    pos_next = pos_inc[5:0];
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = push_reg ? S_EXEC : S_IDLE;
                    push_next  = 1'b0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            style_reg <= 4'h0;
            phase_reg <= PH_PLAIN;
            acc_reg   <= 8'h00;
            row_reg   <= 6'd0;
            len_reg   <= 3'd0;
            push_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            row_reg   <= row_next;
            len_reg   <= len_next;
            push_reg  <= push_next;
            if (cfg_write)
            begin
                style_reg <= pwdata[3:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= mode;
            ch_reg   <= data_byte;
        end
        pos_reg    <= pos_next;
        status_reg <= status_next;
        obyte_reg  <= obyte_next;
        last_reg   <= last_next;
    end

endmodule
